@@ sv/assert_macros.svh @@
// Assertion macros used by the checker of the pitch note segmenter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PNS_ASSERT_SAME(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PNS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ sv/pns_pkg.sv @@
// Package of the pitch note segmenter: payload and configuration types,
// state codes, register indexes and constants. It depends on nothing.
`default_nettype none

package pns_pkg;

    localparam int PITCH_BINS_DEF = 150;
    localparam int COUNT_BITS_DEF = 16;

    // Pitches at or above this integer value never enter the histogram.
    localparam int PITCH_LIMIT = 150;

    // A mode qualifies when SHARE_NUM * mode_count >= SHARE_DEN * qualified.
    localparam int SHARE_NUM = 20;
    localparam int SHARE_DEN = 7;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    localparam logic [15:0] COARSE_RESET    = 16'd256;
    localparam logic [15:0] FINE_RESET      = 16'd256;
    localparam logic        USE_FINE_RESET  = 1'b0;
    localparam logic [15:0] MIN_DUR_RESET   = 16'd25;
    localparam logic [7:0]  MIN_PITCH_RESET = 8'd20;
    localparam logic [15:0] FRAME_LEN_RESET = 16'd512;

    typedef enum logic [2:0] {
        CFG_COARSE    = 3'd0,
        CFG_FINE      = 3'd1,
        CFG_USE_FINE  = 3'd2,
        CFG_MIN_DUR   = 3'd3,
        CFG_MIN_PITCH = 3'd4,
        CFG_FRAME_LEN = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] coarse_threshold;
        logic [15:0] fine_threshold;
        logic        use_fine;
        logic [15:0] min_duration;
        logic [7:0]  min_pitch;
        logic [15:0] frame_length;
    } cfg_t;

    typedef struct packed {
        logic [15:0] velocity;
        logic [15:0] pitch;
        logic [31:0] sample_time;
    } frame_t;

    typedef struct packed {
        logic [31:0] note_start;
        logic [31:0] note_end;
        logic [7:0]  note_pitch;
    } note_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_JUDGE,
        ST_SCAN,
        ST_TAIL,
        ST_DECIDE
    } seg_state_t;

endpackage

`default_nettype wire

@@ sv/pns_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing; a read of an entry written in the same cycle returns old data.
`default_nettype none

module pns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 150
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/pns_cfg.sv @@
// Configuration register file of the pitch note segmenter behind an APB-style port.
// Depends on pns_pkg for the register layout, indexes and reset values.
`default_nettype none

module pns_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pns_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [pns_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [pns_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output pns_pkg::cfg_t                         cfg
);

    pns_pkg::cfg_t     cfg_reg;
    pns_pkg::cfg_idx_t idx;
    logic              wr_en;

    assign idx    = pns_pkg::cfg_idx_t'(paddr[pns_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coarse_threshold <= pns_pkg::COARSE_RESET;
            cfg_reg.fine_threshold   <= pns_pkg::FINE_RESET;
            cfg_reg.use_fine         <= pns_pkg::USE_FINE_RESET;
            cfg_reg.min_duration     <= pns_pkg::MIN_DUR_RESET;
            cfg_reg.min_pitch        <= pns_pkg::MIN_PITCH_RESET;
            cfg_reg.frame_length     <= pns_pkg::FRAME_LEN_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                pns_pkg::CFG_COARSE:    cfg_reg.coarse_threshold <= pwdata[15:0];
                pns_pkg::CFG_FINE:      cfg_reg.fine_threshold   <= pwdata[15:0];
                pns_pkg::CFG_USE_FINE:  cfg_reg.use_fine         <= pwdata[0];
                pns_pkg::CFG_MIN_DUR:   cfg_reg.min_duration     <= pwdata[15:0];
                pns_pkg::CFG_MIN_PITCH: cfg_reg.min_pitch        <= pwdata[7:0];
                pns_pkg::CFG_FRAME_LEN: cfg_reg.frame_length     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pns_pkg::CFG_COARSE:    prdata = 32'(cfg_reg.coarse_threshold);
            pns_pkg::CFG_FINE:      prdata = 32'(cfg_reg.fine_threshold);
            pns_pkg::CFG_USE_FINE:  prdata = 32'(cfg_reg.use_fine);
            pns_pkg::CFG_MIN_DUR:   prdata = 32'(cfg_reg.min_duration);
            pns_pkg::CFG_MIN_PITCH: prdata = 32'(cfg_reg.min_pitch);
            pns_pkg::CFG_FRAME_LEN: prdata = 32'(cfg_reg.frame_length);
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/pitch_note_segmenter.sv @@
// Top level of the pitch note segmenter: run tracking, histogram control and note output.
// Depends on pns_pkg, pns_cfg and pns_ram.
//
//   Channel  Direction  Handshake            Payload
//   frame    in         frame_valid/ready    pns_pkg::frame_t (velocity, pitch, sample_time)
//   note     out        note_valid/ready     pns_pkg::note_t (note_start, note_end, note_pitch)
//   config   in         psel/penable/pready  paddr, pwdata, prdata (APB style)
//
// A frame that extends the current run reads its histogram bin when it is taken and, if its
// pitch qualifies, writes the incremented count back in the update state. A frame that ends
// a run passes through the judge, scan, tail and decide states; the scan reads the histogram
// memory one bin per cycle. After reset the histogram memory is cleared in a pass over all
// PITCH_BINS bins, during which no frame request is taken; configuration writes are taken at
// all times. A pending note waits in the output register while new frames are taken; only a
// second note behind an untaken one holds the block in its decision state.
`default_nettype none

module pitch_note_segmenter #(
    parameter int PITCH_BINS = pns_pkg::PITCH_BINS_DEF,
    parameter int COUNT_BITS = pns_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             frame_valid,
    output logic                                  frame_ready,
    input  wire pns_pkg::frame_t                  frame,
    output logic                                  note_valid,
    input  wire logic                             note_ready,
    output pns_pkg::note_t                        note,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [pns_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [pns_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic      [pns_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                  pready
);

    localparam int IDX_W   = $clog2(PITCH_BINS);
    localparam int PROD_W  = (16 + COUNT_BITS > 32) ? 16 + COUNT_BITS : 32;
    localparam int DUR_W   = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam int SHARE_W = COUNT_BITS + 5;
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(PITCH_BINS - 1);
    localparam logic [15:0] PITCH_CAP = 16'(pns_pkg::PITCH_LIMIT * 256);

    // Configuration registers.
    pns_pkg::cfg_t cfg;

    pns_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer state and the scan index, which also serves the clearing pass after reset.
    pns_pkg::seg_state_t state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    // Run state that lives in flip-flops; the histogram lives in the memory.
    logic [COUNT_BITS-1:0] run_length_reg;
    logic [31:0]           pitch_sum_reg;
    logic [31:0]           run_start_reg;
    logic [31:0]           run_end_reg;
    logic [COUNT_BITS-1:0] qual_cnt_reg;

    // Per-frame and per-judgement working registers.
    logic                  qual_reg;
    logic [IDX_W-1:0]      bin_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic                  pass_reg;
    logic                  scan_vld_reg;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [COUNT_BITS-1:0] best_reg;
    logic [IDX_W-1:0]      mode_reg;

    // Output register.
    logic                  note_valid_reg;
    pns_pkg::note_t        note_reg;

    // Histogram memory ports.
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    pns_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PITCH_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Frame decode, valid only while a request is being taken.
    logic        frame_acc;
    logic [15:0] threshold;
    logic        extend;
    logic        qualify;
    logic [32:0] sum_wide;

    assign frame_ready = (state_reg == pns_pkg::ST_IDLE);
    assign frame_acc   = frame_valid && frame_ready;
    assign threshold   = cfg.use_fine ? cfg.fine_threshold : cfg.coarse_threshold;
    assign extend      = frame.velocity < threshold;
    assign qualify     = (frame.pitch > {cfg.min_pitch, 8'h00}) && (frame.pitch < PITCH_CAP)
                         && ({1'b0, frame.pitch[15:8]} < 9'(PITCH_BINS));
    assign sum_wide    = {1'b0, pitch_sum_reg} + {17'b0, frame.pitch};

    // Run-end tests. The mean test compares against the product registered at acceptance.
    logic               judge_pass;
    logic [SHARE_W-1:0] share_lhs;
    logic [SHARE_W-1:0] share_rhs;
    logic               emit;
    logic               out_blocked;

    assign judge_pass = (DUR_W'(run_length_reg) > DUR_W'(cfg.min_duration))
                        && (PROD_W'(pitch_sum_reg) > prod_reg)
                        && (qual_cnt_reg != '0);
    assign share_lhs  = SHARE_W'(best_reg) * SHARE_W'(pns_pkg::SHARE_NUM);
    assign share_rhs  = SHARE_W'(qual_cnt_reg) * SHARE_W'(pns_pkg::SHARE_DEN);
    assign emit       = pass_reg && (share_lhs >= share_rhs) && (mode_reg != '0)
                        && (run_end_reg > run_start_reg);
    assign out_blocked = note_valid_reg && !note_ready;

    // Histogram memory access. A scan reads each bin and zeroes it in the same cycle;
    // the memory returns the old count in the following cycle.
    always_comb
    begin
        case (state_reg)
            pns_pkg::ST_SCAN: ram_raddr = idx_reg;
            default:          ram_raddr = IDX_W'(frame.pitch[15:8]);
        endcase
        ram_we    = (state_reg == pns_pkg::ST_CLEAR) || (state_reg == pns_pkg::ST_SCAN)
                    || ((state_reg == pns_pkg::ST_UPDATE) && qual_reg);
        ram_waddr = (state_reg == pns_pkg::ST_UPDATE) ? bin_reg : idx_reg;
        if (state_reg == pns_pkg::ST_UPDATE)
        begin
            ram_wdata = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
        end
        else
        begin
            ram_wdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pns_pkg::ST_CLEAR;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            pns_pkg::ST_CLEAR:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_BIN)
                begin
                    idx_next   = '0;
                    state_next = pns_pkg::ST_IDLE;
                end
            end
            pns_pkg::ST_IDLE:
            begin
                if (frame_acc)
                begin
                    state_next = extend ? pns_pkg::ST_UPDATE : pns_pkg::ST_JUDGE;
                end
            end
            pns_pkg::ST_UPDATE:
            begin
                state_next = pns_pkg::ST_IDLE;
            end
            pns_pkg::ST_JUDGE:
            begin
                idx_next   = '0;
                state_next = pns_pkg::ST_SCAN;
            end
            pns_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_BIN)
                begin
                    idx_next   = '0;
                    state_next = pns_pkg::ST_TAIL;
                end
            end
            pns_pkg::ST_TAIL:
            begin
                state_next = pns_pkg::ST_DECIDE;
            end
            pns_pkg::ST_DECIDE:
            begin
                if (!(emit && out_blocked))
                begin
                    state_next = pns_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pns_pkg::ST_IDLE;
            end
        endcase
    end

    // Run state: extended by each frame below the threshold, cleared when a run is judged.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_length_reg <= '0;
            pitch_sum_reg  <= '0;
            run_start_reg  <= '0;
            run_end_reg    <= '0;
            qual_cnt_reg   <= '0;
            qual_reg       <= 1'b0;
            scan_vld_reg   <= 1'b0;
            note_valid_reg <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= (state_reg == pns_pkg::ST_SCAN);

            if (frame_acc && extend)
            begin
                if (run_length_reg == '0)
                begin
                    run_start_reg <= frame.sample_time;
                end
                run_end_reg    <= frame.sample_time + {16'b0, cfg.frame_length};
                run_length_reg <= (&run_length_reg) ? run_length_reg
                                                    : run_length_reg + 1'b1;
                pitch_sum_reg  <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                qual_reg       <= qualify;
                if (qualify && !(&qual_cnt_reg))
                begin
                    qual_cnt_reg <= qual_cnt_reg + 1'b1;
                end
            end
            else if ((state_reg == pns_pkg::ST_DECIDE) && !(emit && out_blocked))
            begin
                run_length_reg <= '0;
                pitch_sum_reg  <= '0;
                run_start_reg  <= '0;
                run_end_reg    <= '0;
                qual_cnt_reg   <= '0;
            end

            // A new note is loaded only when the output register is free or being drained.
            if ((state_reg == pns_pkg::ST_DECIDE) && emit && !out_blocked)
            begin
                note_valid_reg <= 1'b1;
            end
            else if (note_valid_reg && note_ready)
            begin
                note_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers that carry no reset.
    always_ff @(posedge clk)
    begin
        if (frame_acc)
        begin
            bin_reg  <= IDX_W'(frame.pitch[15:8]);
            prod_reg <= PROD_W'({cfg.min_pitch, 8'h00}) * PROD_W'(run_length_reg);
        end

        if (state_reg == pns_pkg::ST_JUDGE)
        begin
            pass_reg <= judge_pass;
            best_reg <= '0;
            mode_reg <= '0;
        end
        else if (scan_vld_reg && (ram_rdata > best_reg))
        begin
            // Strictly greater keeps the lowest bin on ties.
            best_reg <= ram_rdata;
            mode_reg <= scan_idx_reg;
        end

        scan_idx_reg <= idx_reg;

        if ((state_reg == pns_pkg::ST_DECIDE) && emit && !out_blocked)
        begin
            note_reg.note_start <= run_start_reg;
            note_reg.note_end   <= run_end_reg;
            note_reg.note_pitch <= 8'(mode_reg);
        end
    end

    assign note_valid = note_valid_reg;
    assign note       = note_reg;

endmodule

`default_nettype wire

@@ sv/pns_checker.sv @@
// Port-level checker of the pitch note segmenter, bound to the top level.
// Depends on pns_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module pns_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            frame_valid,
    input wire logic            frame_ready,
    input wire logic            note_valid,
    input wire logic            note_ready,
    input wire pns_pkg::note_t  note
);

    // A waiting note keeps its payload until it is taken.
    `PNS_ASSERT_NEXT(a_note_hold, note_valid && !note_ready, note_valid && $stable(note), "note changed while stalled")

    // Every note spans a positive stretch of time.
    `PNS_ASSERT_SAME(a_note_span, note_valid, note.note_end > note.note_start, "note end not after start")

    // The mode is a nonzero pitch below the histogram limit.
    `PNS_ASSERT_SAME(a_note_pitch, note_valid, (note.note_pitch != 8'd0) && (note.note_pitch < 8'(pns_pkg::PITCH_LIMIT)), "note pitch out of range")

    // Each taken frame leaves the block busy, so no two frame requests are taken back to back.
    `PNS_ASSERT_NEXT(a_frame_busy, frame_valid && frame_ready, !frame_ready, "frame request taken back to back")

endmodule

bind pitch_note_segmenter pns_checker u_pns_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .note_valid  (note_valid),
    .note_ready  (note_ready),
    .note        (note)
);

`default_nettype wire
